FILE: rtl/postfix_expression_evaluator_defines.svh
// Assertion macros shared by the postfix evaluator RTL.
// Used by files that hold assertions; each macro expects clk and arst_n in scope.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PFX_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define PFX_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/pfx_pkg.sv
// Shared types and constants of the postfix expression evaluator.
// Used by the controller, the datapath, the divider and the top level; no dependencies.
package pfx_pkg;

	// Word width of the stack and the arithmetic.
	localparam int WORD_W = 32;

	// Default sizes handed down from the top level.
	localparam int STACK_DEPTH_DEF = 16;
	localparam int MAX_DIGITS_DEF  = 4;

	// Character codes of interest.
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_MUL  = 8'h2A;
	localparam logic [7:0] CH_ADD  = 8'h2B;
	localparam logic [7:0] CH_SUB  = 8'h2D;
	localparam logic [7:0] CH_DIV  = 8'h2F;

	// Sticky error codes.
	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_OVERFLOW  = 3'd1,
		ERR_UNDERFLOW = 3'd2,
		ERR_DIVZERO   = 3'd3,
		ERR_TOOLONG   = 3'd4
	} pfx_err_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic op_exec;
		logic op_write;
		logic drain_load;
	} pfx_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic op_go;
		logic op_is_div;
		logic div_zero;
		logic div_done;
		logic out_free;
		logic drain_last;
	} pfx_status_t;

endpackage

FILE: rtl/pfx_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on pfx_pkg and the assertion macros header.
`include "postfix_expression_evaluator_defines.svh"

module pfx_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [pfx_pkg::WORD_W-1:0]   dividend,
	input  logic [pfx_pkg::WORD_W-1:0]   divisor,
	output logic                         done,
	output logic [pfx_pkg::WORD_W-1:0]   quotient
);

	localparam int WW = pfx_pkg::WORD_W;
	localparam int SW = $clog2(WW);

	logic          busy_q;
	logic          done_q;
	logic          neg_q;
	logic [SW-1:0] step_q;
	logic [WW-1:0] rem_q;
	logic [WW-1:0] quo_q;
	logic [WW-1:0] dvs_q;
	logic [WW-1:0] mag_a;
	logic [WW-1:0] mag_b;
	logic [WW:0]   shifted;
	logic [WW+1:0] diff;
	logic          fits;

	// Magnitudes of the operands; the most negative value maps onto itself as unsigned.
	assign mag_a = dividend[WW-1] ? (WW'(0) - dividend) : dividend;
	assign mag_b = divisor[WW-1] ? (WW'(0) - divisor) : divisor;

	// One restoring step: shift in the next dividend bit and try to subtract.
	assign shifted = {rem_q, quo_q[WW-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
	assign fits    = !diff[WW+1];

	// Step counter and done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == SW'(WW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift registers.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= mag_a;
			dvs_q <= mag_b;
			neg_q <= dividend[WW-1] ^ divisor[WW-1];
		end else if (busy_q) begin
			rem_q <= fits ? diff[WW-1:0] : shifted[WW-1:0];
			quo_q <= {quo_q[WW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (WW'(0) - quo_q) : quo_q;

	`PFX_ASSERT_NEXT(a_done_single, done_q, !done_q, "divider done lasted more than one cycle")

endmodule

FILE: rtl/pfx_dp.sv
// Datapath of the postfix evaluator: digit collector, value stack memory, ALU and output register.
// Depends on pfx_pkg, pfx_div and the assertion macros header.
`include "postfix_expression_evaluator_defines.svh"

module pfx_dp #(
	parameter int STACK_DEPTH = pfx_pkg::STACK_DEPTH_DEF,
	parameter int MAX_DIGITS  = pfx_pkg::MAX_DIGITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pfx_pkg::pfx_cmd_t           cmd,
	output pfx_pkg::pfx_status_t        status,
	input  logic [7:0]                  char_code,
	input  logic                        out_stall,
	output logic                        out_valid,
	output logic signed [31:0]          stack_value,
	output logic                        stack_empty,
	output logic [2:0]                  error_code,
	output logic                        final_entry
);

	localparam int WW = pfx_pkg::WORD_W;
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int PW = $clog2(10 ** MAX_DIGITS);
	localparam int DW = $clog2(MAX_DIGITS + 1);

	typedef enum logic [1:0] {OP_MUL, OP_ADD, OP_SUB, OP_DIV} op_t;

	logic [CW-1:0]     cnt_q;
	logic [PW-1:0]     pending_q;
	logic [DW-1:0]     dcnt_q;
	pfx_pkg::pfx_err_t err_q;
	op_t               op_q;
	logic              out_valid_q;
	logic [WW-1:0]     res_q;
	logic [WW-1:0]     top_rd_q;
	logic [WW-1:0]     nxt_rd_q;
	logic [WW-1:0]     value_q;
	logic              empty_q;
	logic              final_q;
	logic [2:0]        error_q;
	logic [WW-1:0]     stack_mem [STACK_DEPTH];

	logic              is_digit;
	logic              is_op;
	logic              is_sep;
	logic              full;
	logic              cnt_ge2;
	logic              digits_room;
	logic [3:0]        digit_val;
	logic [PW+3:0]     pend_x10;
	op_t               op_dec;
	logic              push_en;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [WW-1:0]     wr_data;
	logic [AW-1:0]     top_addr;
	logic [AW-1:0]     nxt_addr;
	logic              div_zero;
	logic              div_start;
	logic              div_done;
	logic [WW-1:0]     div_quot;
	logic              drain_last;
	logic              out_free;
	logic              err_set;
	pfx_pkg::pfx_err_t err_new;

	// Character classes.
	assign is_digit = (char_code >= pfx_pkg::CH_ZERO) && (char_code <= pfx_pkg::CH_NINE);
	assign is_op    = (char_code == pfx_pkg::CH_MUL) || (char_code == pfx_pkg::CH_ADD) ||
	                  (char_code == pfx_pkg::CH_SUB) || (char_code == pfx_pkg::CH_DIV);
	assign is_sep   = !is_digit && !is_op;

	// Decimal digits sit in the low nibble of their character code.
	assign digit_val   = char_code[3:0];
	assign pend_x10    = (PW+4)'({pending_q, 3'b000}) + (PW+4)'({pending_q, 1'b0}) +
	                     (PW+4)'(digit_val);
	assign digits_room = dcnt_q < DW'(MAX_DIGITS);

	always_comb begin
		op_dec = OP_ADD;
		priority if (char_code == pfx_pkg::CH_MUL) begin
			op_dec = OP_MUL;
		end else if (char_code == pfx_pkg::CH_SUB) begin
			op_dec = OP_SUB;
		end else if (char_code == pfx_pkg::CH_DIV) begin
			op_dec = OP_DIV;
		end
	end

	// Stack occupancy.
	assign full       = cnt_q == CW'(STACK_DEPTH);
	assign cnt_ge2    = cnt_q >= CW'(2);
	assign drain_last = cnt_q <= CW'(1);
	assign top_addr   = AW'(cnt_q - CW'(1));
	assign nxt_addr   = AW'(cnt_q - CW'(2));

	// Single write port: a push of the pending number or an operator result.
	assign push_en = cmd.accept && is_sep && (dcnt_q != '0) && !full;
	assign wr_en   = push_en || cmd.op_write;
	assign wr_addr = push_en ? AW'(cnt_q) : nxt_addr;
	assign wr_data = push_en ? WW'(pending_q) : res_q;

	// Stack memory, reading the two topmost entries every cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_mem[wr_addr] <= wr_data;
		end
		top_rd_q <= stack_mem[top_addr];
		nxt_rd_q <= stack_mem[nxt_addr];
	end

	// Division unit, started once the operands are read and the divisor is nonzero.
	assign div_zero  = top_rd_q == '0;
	assign div_start = cmd.op_exec && (op_q == OP_DIV) && !div_zero;

	pfx_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (nxt_rd_q),
		.divisor  (top_rd_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	// First error of the item, if any; the sticky register keeps only the earliest.
	always_comb begin
		err_set = 1'b0;
		err_new = pfx_pkg::ERR_NONE;
		priority if (cmd.accept && is_digit && !digits_room) begin
			err_set = 1'b1;
			err_new = pfx_pkg::ERR_TOOLONG;
		end else if (cmd.accept && is_op && !cnt_ge2) begin
			err_set = 1'b1;
			err_new = pfx_pkg::ERR_UNDERFLOW;
		end else if (cmd.accept && is_sep && (dcnt_q != '0) && full) begin
			err_set = 1'b1;
			err_new = pfx_pkg::ERR_OVERFLOW;
		end else if (cmd.op_exec && (op_q == OP_DIV) && div_zero) begin
			err_set = 1'b1;
			err_new = pfx_pkg::ERR_DIVZERO;
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	// Stack count, digit collector, sticky error and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			pending_q   <= '0;
			dcnt_q      <= '0;
			err_q       <= pfx_pkg::ERR_NONE;
			op_q        <= OP_ADD;
			out_valid_q <= 1'b0;
		end else begin
			if (err_set && (err_q == pfx_pkg::ERR_NONE)) begin
				err_q <= err_new;
			end
			if (cmd.accept) begin
				if (is_digit) begin
					if (digits_room) begin
						pending_q <= PW'(pend_x10);
						dcnt_q    <= dcnt_q + 1'b1;
					end
				end else if (is_op) begin
					op_q <= op_dec;
				end else if (dcnt_q != '0) begin
					if (!full) begin
						cnt_q <= cnt_q + 1'b1;
					end
					pending_q <= '0;
					dcnt_q    <= '0;
				end
			end
			if (cmd.op_write) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.drain_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			// The last drained entry clears the stack count, the pending number and the sticky error.
			if (cmd.drain_load) begin
				if (drain_last) begin
					cnt_q     <= '0;
					pending_q <= '0;
					dcnt_q    <= '0;
					err_q     <= pfx_pkg::ERR_NONE;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Operator result, from the ALU or the divider.
	always_ff @(posedge clk) begin
		if (cmd.op_exec) begin
			unique case (op_q)
				OP_MUL: res_q <= nxt_rd_q * top_rd_q;
				OP_ADD: res_q <= nxt_rd_q + top_rd_q;
				OP_SUB: res_q <= nxt_rd_q - top_rd_q;
				OP_DIV: res_q <= res_q;
			endcase
		end else if (div_done) begin
			res_q <= div_quot;
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (cmd.drain_load) begin
			value_q <= (cnt_q == '0) ? '0 : top_rd_q;
			empty_q <= cnt_q == '0;
			final_q <= drain_last;
			error_q <= err_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign stack_value = value_q;
	assign stack_empty = empty_q;
	assign error_code  = error_q;
	assign final_entry = final_q;

	assign status.op_go      = is_op && cnt_ge2;
	assign status.op_is_div  = op_q == OP_DIV;
	assign status.div_zero   = div_zero;
	assign status.div_done   = div_done;
	assign status.out_free   = out_free;
	assign status.drain_last = drain_last;

	`PFX_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_q <= CW'(STACK_DEPTH), "stack count beyond depth")
	`PFX_ASSERT_IMPL(a_load_free, cmd.drain_load, out_free, "output loaded while still held")
	`PFX_ASSERT_NEXT(a_op_pop, cmd.op_write, cnt_q == CW'($past(cnt_q) - 1'b1), "operator did not pop one")

endmodule

FILE: rtl/pfx_ctrl.sv
// Controller of the postfix evaluator: sequences operators, division and the stack drain.
// Depends on pfx_pkg; drives the datapath through command and status structs.
module pfx_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  end_of_text,
	output logic                  in_stall,
	input  pfx_pkg::pfx_status_t  status,
	output pfx_pkg::pfx_cmd_t     cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_OP_EXEC,
		S_DIV_WAIT,
		S_OP_WRITE,
		S_DRAIN_RD,
		S_DRAIN_LD
	} state_t;

	state_t state_q;
	logic   eot_q;

	// State register and the remembered end-of-text mark.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			eot_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						eot_q <= end_of_text;
						if (status.op_go) begin
							state_q <= S_OP_EXEC;
						end else if (end_of_text) begin
							state_q <= S_DRAIN_RD;
						end
					end
				end
				S_OP_EXEC: begin
					if (status.op_is_div && status.div_zero) begin
						state_q <= eot_q ? S_DRAIN_RD : S_IDLE;
					end else if (status.op_is_div) begin
						state_q <= S_DIV_WAIT;
					end else begin
						state_q <= S_OP_WRITE;
					end
				end
				S_DIV_WAIT: begin
					if (status.div_done) begin
						state_q <= S_OP_WRITE;
					end
				end
				S_OP_WRITE: begin
					state_q <= eot_q ? S_DRAIN_RD : S_IDLE;
				end
				S_DRAIN_RD: begin
					state_q <= S_DRAIN_LD;
				end
				S_DRAIN_LD: begin
					if (status.out_free) begin
						state_q <= status.drain_last ? S_IDLE : S_DRAIN_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Commands decoded from the state.
	assign in_stall       = state_q != S_IDLE;
	assign cmd.accept     = (state_q == S_IDLE) && in_valid;
	assign cmd.op_exec    = state_q == S_OP_EXEC;
	assign cmd.op_write   = state_q == S_OP_WRITE;
	assign cmd.drain_load = (state_q == S_DRAIN_LD) && status.out_free;

endmodule

FILE: rtl/postfix_expression_evaluator.sv
// Postfix expression evaluator: one text byte per input item, stack drained at end of text.
// Depends on pfx_pkg, pfx_ctrl and pfx_dp.
//
// Input channel: in_valid / in_stall with char_code and end_of_text. Digits build a
// pending number; other non-operator bytes push it; * + - / pop two and push one.
// Output channel: out_valid / out_stall with stack_value, stack_empty, error_code and
// final_entry. Results appear only after a byte marked end_of_text: the stack from top
// to bottom, or a single empty marker, with final_entry on the last one.
// Sequence: a digit or separator is taken without leaving idle. An operator *, + or -
// passes through stack read, ALU and write back. A division waits before write back for
// the divider, which gives one quotient bit per cycle. An operator on fewer than two
// entries only sets the error; a division by zero returns without a write back. The drain
// reads each stack entry from memory and then loads it into the output register. in_stall
// is high from the cycle after an operator on two or more entries or an end byte until the
// block is done. Reset empties the stack and clears the pending number and the sticky
// error; no clearing pass is needed. While out_stall is high the output holds and the
// drain waits; other bytes are still taken while the last result waits.
module postfix_expression_evaluator #(
	parameter int STACK_DEPTH = pfx_pkg::STACK_DEPTH_DEF,
	parameter int MAX_DIGITS  = pfx_pkg::MAX_DIGITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         char_code,
	input  logic               end_of_text,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] stack_value,
	output logic               stack_empty,
	output logic [2:0]         error_code,
	output logic               final_entry
);

	pfx_pkg::pfx_cmd_t    cmd;
	pfx_pkg::pfx_status_t status;

	// Sequencer.
	pfx_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.end_of_text (end_of_text),
		.in_stall    (in_stall),
		.status      (status),
		.cmd         (cmd)
	);

	// Stack, arithmetic and output register.
	pfx_dp #(
		.STACK_DEPTH (STACK_DEPTH),
		.MAX_DIGITS  (MAX_DIGITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.char_code   (char_code),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.stack_value (stack_value),
		.stack_empty (stack_empty),
		.error_code  (error_code),
		.final_entry (final_entry)
	);

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench of the postfix expression evaluator: text bytes in, stack drained out.
// Depends on pfx_pkg and postfix_expression_evaluator; drives random idling on both sides.
module tb_top;

	localparam int DEPTH       = pfx_pkg::STACK_DEPTH_DEF;
	localparam int DIGITS      = pfx_pkg::MAX_DIGITS_DEF;
	localparam int CYCLE_LIMIT = 400000;

	// One text byte waiting to be sent; hold makes the sender wait until the drain is done.
	typedef struct {
		logic [7:0] ch;
		logic       eot;
		bit         hold;
	} text_item_t;

	// One expected entry of a stack drain.
	typedef struct {
		logic [31:0]       value;
		logic              empty;
		pfx_pkg::pfx_err_t err;
		logic              last;
	} drain_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] char_code = '0;
	logic end_of_text = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] stack_value;
	logic stack_empty;
	logic [2:0] error_code;
	logic final_entry;

	text_item_t  text_q[$];
	drain_item_t drain_q[$];
	text_item_t  send_item;
	drain_item_t got_item;

	// Evaluator state kept by the testbench.
	logic [31:0]       calc_stack[DEPTH];
	int                calc_depth;
	logic [13:0]       calc_number;
	int                calc_digits;
	pfx_pkg::pfx_err_t calc_error;

	int mismatch_count = 0;
	int sent_count = 0;
	int cycle_count = 0;
	int gap_left = 0;
	int stall_left = 0;

	postfix_expression_evaluator i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.char_code   (char_code),
		.end_of_text (end_of_text),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.stack_value (stack_value),
		.stack_empty (stack_empty),
		.error_code  (error_code),
		.final_entry (final_entry)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Run limit in case the block hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	function automatic void clear_calc();
		calc_depth  = 0;
		calc_number = '0;
		calc_digits = 0;
		calc_error  = pfx_pkg::ERR_NONE;
	endfunction

	function automatic void raise_error(input pfx_pkg::pfx_err_t code);
		if (calc_error == pfx_pkg::ERR_NONE)
			calc_error = code;
	endfunction

	function automatic bit is_operator(input logic [7:0] ch);
		return ch == pfx_pkg::CH_MUL || ch == pfx_pkg::CH_ADD ||
		       ch == pfx_pkg::CH_SUB || ch == pfx_pkg::CH_DIV;
	endfunction

	// Truncating signed division done on magnitudes, so the most negative value wraps.
	function automatic logic [31:0] trunc_divide(input logic [31:0] lhs, input logic [31:0] rhs);
		logic [31:0] mag_l, mag_r, quot;
		mag_l = lhs[31] ? -lhs : lhs;
		mag_r = rhs[31] ? -rhs : rhs;
		quot  = mag_l / mag_r;
		return (lhs[31] != rhs[31]) ? -quot : quot;
	endfunction

	// Applies one accepted text byte and queues the drain it causes.
	task automatic eval_char(input logic [7:0] ch, input logic eot);
		logic [31:0] lhs, rhs, res;
		drain_item_t d;
		if (ch >= pfx_pkg::CH_ZERO && ch <= pfx_pkg::CH_NINE) begin
			if (calc_digits < DIGITS) begin
				calc_number = 14'(calc_number * 10 + (ch - pfx_pkg::CH_ZERO));
				calc_digits++;
			end else begin
				raise_error(pfx_pkg::ERR_TOOLONG);
			end
		end else if (is_operator(ch)) begin
			if (calc_depth < 2) begin
				raise_error(pfx_pkg::ERR_UNDERFLOW);
			end else begin
				rhs = calc_stack[calc_depth - 1];
				lhs = calc_stack[calc_depth - 2];
				if (ch == pfx_pkg::CH_DIV && rhs == 0) begin
					raise_error(pfx_pkg::ERR_DIVZERO);
				end else begin
					case (ch)
						pfx_pkg::CH_MUL: res = lhs * rhs;
						pfx_pkg::CH_ADD: res = lhs + rhs;
						pfx_pkg::CH_SUB: res = lhs - rhs;
						default:         res = trunc_divide(lhs, rhs);
					endcase
					calc_stack[calc_depth - 2] = res;
					calc_depth--;
				end
			end
		end else if (calc_digits != 0) begin
			if (calc_depth >= DEPTH) begin
				raise_error(pfx_pkg::ERR_OVERFLOW);
			end else begin
				calc_stack[calc_depth] = {18'b0, calc_number};
				calc_depth++;
			end
			calc_number = '0;
			calc_digits = 0;
		end

		if (eot) begin
			if (calc_depth == 0) begin
				d = '{value: '0, empty: 1'b1, err: calc_error, last: 1'b1};
				drain_q.push_back(d);
			end else begin
				for (int i = calc_depth - 1; i >= 0; i--) begin
					d = '{value: calc_stack[i], empty: 1'b0, err: calc_error,
						last: (i == 0)};
					drain_q.push_back(d);
				end
			end
			clear_calc();
		end
	endtask

	// Idling stops near the end of the run and in some stretches.
	function automatic bit quiet_now();
		return text_q.size() < 40 || (sent_count % 128) < 32;
	endfunction

	// Driver: sends text items from the queue with random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			char_code <= '0;
			end_of_text <= 1'b0;
			gap_left = 0;
			clear_calc();
		end else begin
			if (in_valid && !in_stall) begin
				eval_char(char_code, end_of_text);
				sent_count++;
			end
			if (!in_valid || !in_stall) begin
				if (text_q.size() == 0 || gap_left > 0 ||
				    (text_q[0].hold && drain_q.size() != 0)) begin
					if (gap_left > 0)
						gap_left--;
					in_valid <= 1'b0;
				end else if (!quiet_now() && $urandom_range(0, 4) == 0) begin
					gap_left = $urandom_range(0, 2);
					in_valid <= 1'b0;
				end else begin
					send_item = text_q.pop_front();
					in_valid <= 1'b1;
					char_code <= send_item.ch;
					end_of_text <= send_item.eot;
				end
			end
		end
	end

	// Monitor: checks each result against the oldest expectation and stalls at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (drain_q.size() == 0) begin
					report_mismatch($sformatf("result %0d with none expected", stack_value));
				end else begin
					got_item = drain_q.pop_front();
					if (stack_value !== got_item.value)
						report_mismatch($sformatf("stack_value %0d, expected %0d",
							stack_value, $signed(got_item.value)));
					if (stack_empty !== got_item.empty)
						report_mismatch($sformatf("stack_empty %b, expected %b",
							stack_empty, got_item.empty));
					if (error_code !== got_item.err)
						report_mismatch($sformatf("error_code %0d, expected %0d",
							error_code, got_item.err));
					if (final_entry !== got_item.last)
						report_mismatch($sformatf("final_entry %b, expected %b",
							final_entry, got_item.last));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!quiet_now() && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 2);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic add_char(input logic [7:0] ch, input logic eot = 1'b0, input bit hold = 1'b0);
		text_item_t t;
		t = '{ch: ch, eot: eot, hold: hold};
		text_q.push_back(t);
	endtask

	// Queues a string; the last byte carries the end mark when asked.
	task automatic add_text(input string s, input logic eot_last);
		for (int i = 0; i < s.len(); i++)
			add_char(s[i], eot_last && (i == s.len() - 1));
	endtask

	// Mostly a space, otherwise any byte that is neither a digit nor an operator.
	function automatic logic [7:0] rand_separator();
		logic [7:0] ch;
		if ($urandom_range(0, 3) < 2)
			return 8'h20;
		do
			ch = 8'($urandom_range(0, 255));
		while ((ch >= pfx_pkg::CH_ZERO && ch <= pfx_pkg::CH_NINE) || is_operator(ch));
		return ch;
	endfunction

	function automatic logic [7:0] rand_operator();
		case ($urandom_range(0, 3))
			0:       return pfx_pkg::CH_MUL;
			1:       return pfx_pkg::CH_ADD;
			2:       return pfx_pkg::CH_SUB;
			default: return pfx_pkg::CH_DIV;
		endcase
	endfunction

	// Digits of one number; now and then a zero or one that is too long.
	task automatic add_number();
		int n;
		if ($urandom_range(0, 7) == 0) begin
			add_char(pfx_pkg::CH_ZERO);
		end else begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
			repeat (n)
				add_char(pfx_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
		end
	endtask

	// One random expression ending in a byte with the end mark.
	task automatic gen_expression(input bit hold);
		int mode, depth, steps;
		if (hold)
			add_char(rand_separator(), 1'b0, 1'b1);
		mode = $urandom_range(0, 9);
		depth = 0;
		if (mode == 0) begin
			// Noise: any bytes at all.
			steps = $urandom_range(1, 8);
			for (int i = 0; i < steps; i++)
				add_char(8'($urandom_range(0, 255)), i == steps - 1);
		end else if (mode == 1) begin
			// Fill the stack close to, up to or past its depth.
			steps = $urandom_range(DEPTH - 1, DEPTH + 2);
			repeat (steps) begin
				add_number();
				add_char(rand_separator());
			end
			repeat ($urandom_range(0, 3))
				add_char(rand_operator());
			add_char(rand_separator(), 1'b1);
		end else if (mode == 2) begin
			// Most negative value divided by minus one.
			add_text("2048 1024 1024 **0 1 -/", 1'b0);
			add_char(rand_separator(), 1'b1);
		end else begin
			// Well-formed text with random content.
			steps = $urandom_range(3, 14);
			repeat (steps) begin
				if (depth < 2 || $urandom_range(0, 2) == 0) begin
					add_number();
					if ($urandom_range(0, 4) != 0) begin
						add_char(rand_separator());
						depth++;
					end
				end else begin
					add_char(rand_operator());
					depth--;
				end
			end
			if (depth >= 2 && $urandom_range(0, 1) == 0)
				add_char(rand_operator(), 1'b1);
			else
				add_char(rand_separator(), 1'b1);
		end
	endtask

	// Stimulus, reset and end of run.
	initial begin
		int expr_count;

		// Lowest byte alone: empty stack at the end.
		add_char(8'h00, 1'b1);
		// A number that is too long, the highest byte as a separator, a division,
		// a division by zero and an addition on the end byte.
		add_text("99999", 1'b0);
		add_char(8'hFF);
		add_text("3 /0 /+", 1'b1);
		// Operator on an empty stack, a subtraction, and digits pending at the end.
		add_text("*8 2 -7", 1'b1);
		// Multiplication on the end byte.
		add_text("4 5 *", 1'b1);

		expr_count = 0;
		while (text_q.size() < 520) begin
			gen_expression(expr_count % 6 == 0);
			expr_count++;
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (text_q.size() != 0 || in_valid)
			@(posedge clk);
		while (drain_q.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);

		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: postfix_expression_evaluator.f
+incdir+rtl
rtl/pfx_pkg.sv
rtl/pfx_div.sv
rtl/pfx_dp.sv
rtl/pfx_ctrl.sv
rtl/postfix_expression_evaluator.sv
test/tb_top.sv
